// ===== rtl/core/riffscan_pkg.sv =====
`default_nettype none

package riffscan_pkg;

  // field widths
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned RUN_W    = 17;
  localparam int unsigned SKIP_W   = 33;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W    = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIST_RUN_LIMIT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANIH_EXPECTED_SIZE = 1'd1;

  // configuration reset values
  localparam logic [LIMIT_W-1:0] LIST_RUN_LIMIT_RST     = 16'd1000;
  localparam logic [SIZE_W-1:0]  ANIH_EXPECTED_SIZE_RST = 32'd36;

  // four character codes, first byte in the top bits
  localparam logic [31:0] ID_RIFF = 32'h5249_4646;
  localparam logic [31:0] ID_RIFX = 32'h5249_4658;
  localparam logic [31:0] ID_ACON = 32'h4143_4F4E;
  localparam logic [31:0] ID_ANIH = 32'h616E_6968;
  localparam logic [31:0] ID_LIST = 32'h4C49_5354;
  localparam logic [31:0] ID_PROP = 32'h5052_4F50;
  localparam logic [31:0] ID_FORM = 32'h464F_524D;
  localparam logic [31:0] ID_CAT  = 32'h4341_5420;

  // byte positions inside the headers
  localparam logic [IDX_W-1:0] IDX_ID_LAST   = 4'd3;
  localparam logic [IDX_W-1:0] IDX_SIZE_LAST = 4'd7;
  localparam logic [IDX_W-1:0] IDX_FORM_LAST = 4'd11;
  localparam logic [IDX_W-1:0] IDX_SIZE_FIRST = 4'd4;
  localparam logic [IDX_W-1:0] IDX_FORM_FIRST = 4'd8;

  // stop reasons
  localparam logic [2:0] REASON_NOT_RIFF   = 3'd0;
  localparam logic [2:0] REASON_NOT_ACON   = 3'd1;
  localparam logic [2:0] REASON_FILE_ENDED = 3'd2;
  localparam logic [2:0] REASON_NESTED     = 3'd3;
  localparam logic [2:0] REASON_LIST_LIMIT = 3'd4;
  localparam logic [2:0] REASON_BAD_ANIH   = 3'd5;

  typedef enum logic [1:0] {
    PH_FILE_HDR,
    PH_CHUNK_HDR,
    PH_LIST_TYPE,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       exploit_found;
    logic [2:0] stop_reason;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/riff_ani_header_exploit_scan.sv =====
`default_nettype none

// channel  | direction | payload     | handshake
// in_      | input     | in_item_t   | in_valid / in_ready
// out_     | output    | out_item_t  | out_valid / out_ready
// cfg_     | input     | 32 bit data | cfg_we, no wait
//
// one byte is taken per cycle; its verdict, if any, shows on out_ the next cycle
// a full output register stalls input only while out_ready is low
// each byte updates counters and shift registers in a single registered pass
// rst_n clears the parse state and out_valid and loads register defaults
// no clearing pass; the block takes bytes from the first cycle after reset

module riff_ani_header_exploit_scan
  import riffscan_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  // configuration registers
  logic [LIMIT_W-1:0] limit_r;
  logic [SIZE_W-1:0]  anih_size_r;

  // parse state
  phase_t             phase_r, phase_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [31:0]        id_r, id_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [SKIP_W-1:0]  skip_r, skip_nxt;
  logic               big_r, big_nxt;
  logic [RUN_W-1:0]   run_r, run_nxt;
  logic               verdict_r, verdict_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  // decision of the current byte
  logic               stop;
  logic [2:0]         reason;

  logic               in_xfer;
  logic               consume;
  logic [7:0]         b;
  logic               last;
  logic [31:0]        id_shift;
  logic [SIZE_W-1:0]  size_new;
  logic [RUN_W-1:0]   run_inc;
  logic [SKIP_W-1:0]  skip_load;
  logic [SKIP_W-1:0]  skip_dec;
  logic               is_anih;
  logic               is_riff_id;
  logic               is_list_id;
  logic               run_over;
  logic               run_inc_over;
  logic               run_one_over;

  // handshake
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign consume   = in_xfer && !verdict_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // shared decode
  assign b         = in_data.data_byte;
  assign last      = in_data.last_byte;
  assign id_shift  = {id_r[23:0], b};
  assign size_new  = big_r ? {size_r[23:0], b} : {b, size_r[31:8]};
  assign run_inc   = (run_r == {RUN_W{1'b1}}) ? run_r : run_r + RUN_W'(1);
  assign skip_load = {1'b0, size_new} + {{SIZE_W{1'b0}}, size_new[0]};
  assign skip_dec  = (skip_r != '0) ? skip_r - SKIP_W'(1) : skip_r;
  assign is_anih   = (id_r == ID_ANIH);
  assign is_riff_id = (id_r == ID_RIFF) || (id_r == ID_RIFX);
  assign is_list_id = (id_r == ID_LIST) || (id_r == ID_PROP) ||
                      (id_r == ID_FORM) || (id_r == ID_CAT);
  assign run_over     = run_r > {1'b0, limit_r};
  assign run_inc_over = run_inc > {1'b0, limit_r};
  assign run_one_over = (limit_r == '0);

  // next parse state; after a verdict the state is unused until the last byte
  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    id_nxt      = id_r;
    size_nxt    = size_r;
    skip_nxt    = skip_r;
    big_nxt     = big_r;
    run_nxt     = run_r;
    verdict_nxt = verdict_r;
    if (consume) begin
      verdict_nxt = stop;
      unique case (phase_r)
        PH_FILE_HDR: begin
          idx_nxt = idx_r + IDX_W'(1);
          if (idx_r < IDX_SIZE_FIRST || idx_r >= IDX_FORM_FIRST) begin
            id_nxt = id_shift;
          end
          if (idx_r == IDX_ID_LAST) begin
            big_nxt = (id_shift == ID_RIFX);
          end else if (idx_r == IDX_FORM_LAST) begin
            phase_nxt = PH_CHUNK_HDR;
            idx_nxt   = '0;
          end
        end
        PH_CHUNK_HDR: begin
          idx_nxt = idx_r + IDX_W'(1);
          if (idx_r < IDX_SIZE_FIRST) begin
            id_nxt = id_shift;
          end else begin
            size_nxt = size_new;
          end
          if (idx_r == IDX_SIZE_LAST) begin
            idx_nxt = '0;
            if (is_list_id) begin
              phase_nxt = PH_LIST_TYPE;
            end else begin
              run_nxt  = RUN_W'(1);
              skip_nxt = skip_load;
              if (skip_load != '0) begin
                phase_nxt = PH_SKIP;
              end
            end
          end
        end
        PH_LIST_TYPE: begin
          idx_nxt = idx_r + IDX_W'(1);
          if (idx_r == IDX_ID_LAST) begin
            run_nxt   = run_inc;
            phase_nxt = PH_CHUNK_HDR;
            idx_nxt   = '0;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            phase_nxt = PH_CHUNK_HDR;
            idx_nxt   = '0;
          end
        end
      endcase
    end
    // the last byte starts a new file
    if (in_xfer && last) begin
      phase_nxt   = PH_FILE_HDR;
      idx_nxt     = '0;
      id_nxt      = '0;
      size_nxt    = '0;
      skip_nxt    = '0;
      big_nxt     = 1'b0;
      run_nxt     = RUN_W'(1);
      verdict_nxt = 1'b0;
    end
  end

  // verdict of the current byte
  always_comb begin
    stop   = 1'b0;
    reason = REASON_FILE_ENDED;
    unique case (phase_r)
      PH_FILE_HDR: begin
        if (idx_r == IDX_ID_LAST) begin
          if (id_shift != ID_RIFF && id_shift != ID_RIFX) begin
            stop   = 1'b1;
            reason = REASON_NOT_RIFF;
          end
        end else if (idx_r == IDX_FORM_LAST) begin
          if (id_shift != ID_ACON) begin
            stop   = 1'b1;
            reason = REASON_NOT_ACON;
          end else if (run_over) begin
            stop   = 1'b1;
            reason = REASON_LIST_LIMIT;
          end
        end
      end
      PH_CHUNK_HDR: begin
        if (idx_r == IDX_SIZE_LAST) begin
          if (is_anih && size_new != anih_size_r) begin
            stop   = 1'b1;
            reason = REASON_BAD_ANIH;
          end else if (is_riff_id) begin
            stop   = 1'b1;
            reason = REASON_NESTED;
          end else if (!is_list_id && skip_load == '0 && run_one_over) begin
            stop   = 1'b1;
            reason = REASON_LIST_LIMIT;
          end
        end
      end
      PH_LIST_TYPE: begin
        if (idx_r == IDX_ID_LAST && run_inc_over) begin
          stop   = 1'b1;
          reason = REASON_LIST_LIMIT;
        end
      end
      PH_SKIP: begin
        if (skip_dec == '0 && run_over) begin
          stop   = 1'b1;
          reason = REASON_LIST_LIMIT;
        end
      end
    endcase
    // early end of file
    if (!stop && last) begin
      stop   = 1'b1;
      reason = REASON_FILE_ENDED;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (consume && stop) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.stop_reason   = reason;
      out_data_nxt.exploit_found = (reason == REASON_BAD_ANIH);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FILE_HDR;
      idx_r       <= '0;
      id_r        <= '0;
      size_r      <= '0;
      skip_r      <= '0;
      big_r       <= 1'b0;
      run_r       <= RUN_W'(1);
      verdict_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      id_r        <= id_nxt;
      size_r      <= size_nxt;
      skip_r      <= skip_nxt;
      big_r       <= big_nxt;
      run_r       <= run_nxt;
      verdict_r   <= verdict_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIST_RUN_LIMIT_RST;
      anih_size_r <= ANIH_EXPECTED_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIST_RUN_LIMIT:     limit_r     <= cfg_wdata[LIMIT_W-1:0];
        CFG_ANIH_EXPECTED_SIZE: anih_size_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/riffscan_chk.sv =====
`default_nettype none

module riffscan_chk
  import riffscan_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire out_item_t            out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // exploit flag only with a bad anih reason
  a_exploit_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.exploit_found == (out_data.stop_reason == REASON_BAD_ANIH)))
    else $error("exploit flag and reason disagree");

  // input stalls only behind a blocked result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  // no result appears without an input transfer
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) && !(in_valid && in_ready) |=> !out_valid)
    else $error("result without input transfer");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind riff_ani_header_exploit_scan riffscan_chk u_riffscan_chk (.*);

`default_nettype wire
